// ===== rtl/b64d_pkg.sv =====
`default_nettype none
package b64d_pkg;

  localparam int unsigned CountBits = 16;
  localparam int unsigned LimitBits = 16;
  localparam int unsigned CmpW = (CountBits > LimitBits) ? CountBits : LimitBits;

  localparam logic [LimitBits-1:0] LimitReset = '1;
  localparam logic [7:0] PadChar = 8'd61;

  // Result queue depth.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LAST = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_FOURTH = 2'd3;

  typedef struct packed {
    logic       is_final;
    logic [7:0] data_byte;
    logic [15:0] byte_count;
    logic [1:0] status;
  } res_t;

  // Sextet value 0..63, or 64 for a character outside the alphabet.
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return 7'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7a) return 7'(c - 8'h61 + 8'd26);
    if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
    if (c == 8'h2b) return 7'd62;
    if (c == 8'h2f) return 7'd63;
    return 7'd64;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b64d_if.sv =====
`default_nettype none
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic        is_final;
  logic [7:0]  data_byte;
  logic [15:0] byte_count;
  logic [1:0]  status;

  modport source (output valid, is_final, data_byte, byte_count, status, input ready);
  modport sink (input valid, is_final, data_byte, byte_count, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/base64_stream_decoder_unit.sv =====
`default_nettype none
// Base64 stream decoder, one character per item.
// The first result of an item passes the input register and the result queue before
// it is offered. Throughput: one item per cycle while the queue has room and each item
// yields at most one result; a data byte plus end-of-string report makes two results.
// Reset (rst_ni, asynchronous, active low) clears the decoder state and queue and sets
// out_limit to 65535.
module base64_stream_decoder_unit
  import b64d_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [LimitBits-1:0] cfg_wdata_i,
  b64d_in_if.sink                   in_i,
  b64d_out_if.source                out_o
);

  logic                 in_valid_q;
  logic [7:0]           ch_q;
  logic                 last_q;
  logic [LimitBits-1:0] out_limit_q;
  logic                 has_room;
  logic                 proc_fire;
  logic [1:0]           n_res;
  res_t                 res0;
  res_t                 res1;

  assign proc_fire = in_valid_q && has_room;
  assign in_i.ready = !in_valid_q || has_room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_limit_q <= LimitReset;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (cfg_we_i) out_limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ch_q   <= in_i.ch;
      last_q <= in_i.last;
    end
  end

  b64d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (proc_fire),
    .ch_i        (ch_q),
    .last_i      (last_q),
    .out_limit_i (out_limit_q),
    .n_res_o     (n_res),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  b64d_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_push_i   (n_res),
    .push0_i    (res0),
    .push1_i    (res1),
    .has_room_o (has_room),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

// ===== rtl/b64d_core.sv =====
`default_nettype none
module b64d_core
  import b64d_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire logic [7:0]           ch_i,
  input  wire logic                 last_i,
  input  wire logic [LimitBits-1:0] out_limit_i,
  output logic [1:0]                n_res_o,
  output res_t                      res0_o,
  output res_t                      res1_o
);

  logic [1:0]           phase_q, phase_d;
  logic [5:0]           prev_q, prev_d;
  logic [CountBits-1:0] bytes_q, bytes_d;
  logic                 fin_q, fin_d;
  logic [1:0]           fail_q, fail_d;

  logic [6:0]  sext;
  logic        skipped;
  logic        emit_want;
  logic        emit_ok;
  logic [7:0]  byte_val;
  logic [1:0]  st_final;
  logic [CmpW-1:0] bytes_ext;
  res_t        data_res;
  res_t        final_res;

  assign sext = sextet_of(ch_i);

  always_comb begin
    unique case (phase_q)
      PH_SECOND: byte_val = {prev_q, sext[5:4]};
      PH_THIRD:  byte_val = {prev_q[3:0], sext[5:2]};
      PH_FOURTH: byte_val = {prev_q[1:0], sext[5:0]};
      default:   byte_val = '0;
    endcase
  end

  // A byte is refused once the count reaches the limit or its own maximum.
  assign emit_ok = (CmpW'(bytes_q) < CmpW'(out_limit_i)) && (bytes_q != '1);

  always_comb begin
    phase_d   = phase_q;
    prev_d    = prev_q;
    bytes_d   = bytes_q;
    fin_d     = fin_q;
    fail_d    = fail_q;
    skipped   = 1'b0;
    emit_want = 1'b0;
    if (!fin_q) begin
      if (phase_q >= PH_THIRD && ch_i == PadChar) begin
        fin_d  = 1'b1;
        fail_d = ST_OK;
      end else if (sext[6]) begin
        skipped = 1'b1;
      end else begin
        if (phase_q != PH_FIRST) begin
          if (emit_ok) begin
            emit_want = 1'b1;
            bytes_d   = bytes_q + 1'b1;
          end else begin
            fin_d  = 1'b1;
            fail_d = ST_FULL;
          end
        end
        phase_d = phase_q + 2'd1;
        prev_d  = sext[5:0];
      end
    end

    priority if (fin_d) st_final = fail_d;
    else if (skipped) st_final = ST_BAD_LAST;
    else if (phase_d != PH_FIRST) st_final = ST_TRUNC;
    else st_final = ST_OK;
    bytes_ext = CmpW'(bytes_d);

    if (last_i) begin
      phase_d = PH_FIRST;
      prev_d  = '0;
      bytes_d = '0;
      fin_d   = 1'b0;
      fail_d  = ST_OK;
    end
  end

  always_comb begin
    data_res.is_final    = 1'b0;
    data_res.data_byte   = byte_val;
    data_res.byte_count  = '0;
    data_res.status      = ST_OK;
    final_res.is_final   = 1'b1;
    final_res.data_byte  = '0;
    final_res.byte_count = (st_final == ST_OK) ? bytes_ext[15:0] : 16'd0;
    final_res.status     = st_final;
    res0_o  = emit_want ? data_res : final_res;
    res1_o  = final_res;
    n_res_o = 2'(emit_want) + 2'(last_i);
    if (!fire_i) n_res_o = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      prev_q  <= '0;
      bytes_q <= '0;
      fin_q   <= 1'b0;
      fail_q  <= ST_OK;
    end else if (fire_i) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      bytes_q <= bytes_d;
      fin_q   <= fin_d;
      fail_q  <= fail_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_queue.sv =====
`default_nettype none
module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic [1:0] n_push_i,
  input  res_t          push0_i,
  input  res_t          push1_i,
  output logic          has_room_o,
  b64d_out_if.source    out_o
);

  res_t           mem_q [QDepth];
  logic [QAw-1:0] wp_q, rp_q;
  logic [QAw:0]   cnt_q;
  logic           pop;
  logic [QAw-1:0] wp_next;

  assign pop        = out_o.valid && out_o.ready;
  assign wp_next    = wp_q + 1'b1;
  // Room for the two results that one item may bring.
  assign has_room_o = cnt_q <= (QAw+1)'(QDepth - 2);

  assign out_o.valid      = cnt_q != '0;
  assign out_o.is_final   = mem_q[rp_q].is_final;
  assign out_o.data_byte  = mem_q[rp_q].data_byte;
  assign out_o.byte_count = mem_q[rp_q].byte_count;
  assign out_o.status     = mem_q[rp_q].status;

  always_ff @(posedge clk_i) begin
    if (n_push_i != 2'd0) mem_q[wp_q] <= push0_i;
    if (n_push_i == 2'd2) mem_q[wp_next] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + QAw'(n_push_i);
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAw+1)'(n_push_i) - (QAw+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_checker.sv =====
`default_nettype none
module b64d_checker
  import b64d_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        is_final_i,
  input wire logic [7:0]  data_byte_i,
  input wire logic [15:0] byte_count_i,
  input wire logic [1:0]  status_i
);

  // A result that is held back stays on offer.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_final_i |-> status_i == ST_OK && byte_count_i == 16'd0)
    else $error("data item carries status or count");

  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_final_i && status_i != ST_OK |-> byte_count_i == 16'd0)
    else $error("failed report carries a byte count");

  a_final_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_final_i |-> data_byte_i == 8'd0)
    else $error("report carries a data byte");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .is_final_i   (out_o.is_final),
  .data_byte_i  (out_o.data_byte),
  .byte_count_i (out_o.byte_count),
  .status_i     (out_o.status)
);
`default_nettype wire
